@@ src/sscp_pkg.sv @@
package sscp_pkg;

  typedef logic [1:0] command_t;

  localparam command_t CMD_NONE  = 2'd0;
  localparam command_t CMD_STEP  = 2'd1;
  localparam command_t CMD_ABORT = 2'd2;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

endpackage

@@ src/serial_step_command_parser.sv @@
// Parses "S:<number>;" step commands and "A;" abort commands from a byte stream, one byte
// per transaction, and gives one result (command, signed saturated step_count) for every ';'.
// A byte is taken in every cycle in which in_stall_o is low; it sits in the input register while
// the parser state is updated, and the result is loaded from there into the output register
// when its ';' is processed. in_stall_o rises only when the byte held in the input register
// is a ';' and the output register still holds a result that the consumer has not taken.
module serial_step_command_parser #(
  parameter int MESSAGE_CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  command_o,
  output logic signed [31:0] step_count_o
);

  localparam int LenW = $clog2(MESSAGE_CAPACITY + 1);

  typedef enum logic [2:0] {
    HDR_START,
    HDR_GOT_S,
    HDR_GOT_A,
    HDR_NUMBER,
    HDR_BAD
  } hdr_e;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  logic            b_vld_q;
  logic [7:0]      byte_q;
  logic            o_vld_q;
  sscp_pkg::command_t cmd_q, cmd_d;
  logic [31:0]     cnt_q, cnt_d;

  logic [LenW-1:0] len_q, len_d, len_eff;
  hdr_e            hdr_q, hdr_d, hdr_eff;
  phase_e          phase_q, phase_d, phase_eff;
  logic            neg_q, neg_d, neg_eff;
  logic [31:0]     mag_q, mag_d, mag_eff;

  logic            out_load;
  logic            is_end;
  logic            proc;
  logic            restart;
  logic            is_digit;
  logic            is_blank;
  logic [35:0]     mag_next;
  logic [31:0]     mag_acc;

  assign out_load   = !o_vld_q || !out_stall_i;
  assign is_end     = (byte_q == sscp_pkg::CH_SEMI);
  assign proc       = b_vld_q && (!is_end || out_load);
  assign in_stall_o = b_vld_q && !proc;

  assign out_valid_o  = o_vld_q;
  assign command_o    = cmd_q;
  assign step_count_o = cnt_q;

  assign restart   = (len_q >= LenW'(MESSAGE_CAPACITY));
  assign len_eff   = restart ? '0 : len_q;
  assign hdr_eff   = restart ? HDR_START : hdr_q;
  assign phase_eff = restart ? PH_SKIP : phase_q;
  assign neg_eff   = restart ? 1'b0 : neg_q;
  assign mag_eff   = restart ? '0 : mag_q;

  assign is_digit = (byte_q >= sscp_pkg::CH_ZERO) && (byte_q <= sscp_pkg::CH_NINE);
  assign is_blank = (byte_q == sscp_pkg::CH_SPACE) ||
                    ((byte_q >= sscp_pkg::CH_TAB) && (byte_q <= sscp_pkg::CH_CR));

  // mag * 10 + digit, clamped to 2^31
  assign mag_next = {mag_eff, 3'b000} + {2'b00, mag_eff, 1'b0}
                  + {32'd0, byte_q[3:0] - sscp_pkg::CH_ZERO[3:0]};
  assign mag_acc  = (mag_next > {4'd0, sscp_pkg::MAG_CAP}) ? sscp_pkg::MAG_CAP
                                                            : mag_next[31:0];

  always_comb begin
    len_d   = len_eff + LenW'(1);
    hdr_d   = hdr_eff;
    phase_d = phase_eff;
    neg_d   = neg_eff;
    mag_d   = mag_eff;
    cmd_d   = sscp_pkg::CMD_NONE;
    cnt_d   = '0;
    if (is_end) begin
      if (hdr_eff == HDR_NUMBER) begin
        cmd_d = sscp_pkg::CMD_STEP;
        if (neg_eff) begin
          cnt_d = 32'd0 - mag_eff;
        end else begin
          cnt_d = (mag_eff > sscp_pkg::POS_MAX) ? sscp_pkg::POS_MAX : mag_eff;
        end
      end else if (hdr_eff == HDR_GOT_A) begin
        cmd_d = sscp_pkg::CMD_ABORT;
      end
      len_d   = '0;
      hdr_d   = HDR_START;
      phase_d = PH_SKIP;
      neg_d   = 1'b0;
      mag_d   = '0;
    end else begin
      case (hdr_eff)
        HDR_START: begin
          if (byte_q == sscp_pkg::CH_S) begin
            hdr_d = HDR_GOT_S;
          end else if (byte_q == sscp_pkg::CH_A) begin
            hdr_d = HDR_GOT_A;
          end else begin
            hdr_d = HDR_BAD;
          end
        end
        HDR_GOT_S: hdr_d = (byte_q == sscp_pkg::CH_COLON) ? HDR_NUMBER : HDR_BAD;
        HDR_NUMBER: begin
          case (phase_eff)
            PH_SKIP: begin
              if (!is_blank) begin
                if ((byte_q == sscp_pkg::CH_PLUS) || (byte_q == sscp_pkg::CH_MINUS)) begin
                  neg_d   = (byte_q == sscp_pkg::CH_MINUS);
                  phase_d = PH_DIGITS;
                end else if (is_digit) begin
                  mag_d   = mag_acc;
                  phase_d = PH_DIGITS;
                end else begin
                  phase_d = PH_DONE;
                end
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                mag_d = mag_acc;
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: phase_d = phase_eff;
          endcase
        end
        default: hdr_d = HDR_BAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
      cmd_q   <= sscp_pkg::CMD_NONE;
      cnt_q   <= '0;
      len_q   <= '0;
      hdr_q   <= HDR_START;
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else begin
      // input register refills whenever it is empty or drains this cycle
      if (!b_vld_q || proc) begin
        b_vld_q <= in_valid_i;
      end
      if (out_load) begin
        o_vld_q <= proc && is_end;
      end
      if (proc && is_end) begin
        cmd_q <= cmd_d;
        cnt_q <= cnt_d;
      end
      if (proc) begin
        len_q   <= len_d;
        hdr_q   <= hdr_d;
        phase_q <= phase_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MESSAGE_CAPACITY))
    else $error("message length beyond capacity");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && is_end |=> (hdr_q == HDR_START) && (len_q == '0) && (mag_q == '0))
    else $error("message not restarted after terminator");

  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q != HDR_NUMBER |-> phase_q == PH_SKIP)
    else $error("number phase advanced outside step number");

  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_o != sscp_pkg::CMD_STEP) |-> step_count_o == 32'sd0)
    else $error("nonzero count on non-step result");

  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (command_o == sscp_pkg::CMD_NONE) || (command_o == sscp_pkg::CMD_STEP) ||
                    (command_o == sscp_pkg::CMD_ABORT))
    else $error("undefined command code");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && is_end |=> out_valid_o)
    else $error("terminator produced no result");

endmodule
